// ===== hdl/tkes_pkg.sv =====
// shared constants and types for the top-k elite selector
`default_nettype none

package tkes_pkg;

    localparam int ELITE_SLOTS = 8;
    localparam int IDX_W       = 10;
    localparam int FIT_W       = 16;
    localparam int RANK_W      = 3;
    localparam int CNT_W       = (ELITE_SLOTS > 1) ? $clog2(ELITE_SLOTS) : 1;

    typedef enum logic [0:0] {
        ST_COLLECT,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic insert;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_slot;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hdl/tkes_ctrl.sv =====
// controller state machine for the top-k elite selector
`default_nettype none

module tkes_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic              i_population_end,
    input  wire tkes_pkg::t_dp_stat i_stat,
    output tkes_pkg::t_dp_cmd      o_cmd,
    output logic                   busy
);

    tkes_pkg::t_state r_state;
    tkes_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tkes_pkg::ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.insert = 1'b0;
        o_cmd.emit   = 1'b0;
        busy         = 1'b0;
        case (r_state)
            tkes_pkg::ST_COLLECT: begin
                o_cmd.insert = start;
                if (start && i_population_end) begin
                    n_state = tkes_pkg::ST_EMIT;
                end
            end
            tkes_pkg::ST_EMIT: begin
                busy       = 1'b1;
                o_cmd.emit = 1'b1;
                if (i_stat.last_slot) begin
                    n_state = tkes_pkg::ST_COLLECT;
                end
            end
            default: begin
                n_state = tkes_pkg::ST_COLLECT;
            end
        endcase
    end

    a_no_insert_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_cmd.insert)
        else $error("insert issued while emitting");

    a_emit_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> busy)
        else $error("readout issued while collecting");

    a_insert_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.insert |-> start)
        else $error("insert issued without a request");

endmodule

`default_nettype wire

// ===== hdl/tkes_datapath.sv =====
// slot registers, parallel compare-and-shift insert and rank readout
`default_nettype none

module tkes_datapath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire tkes_pkg::t_dp_cmd                  i_cmd,
    input  wire logic [tkes_pkg::IDX_W-1:0]         i_member_index,
    input  wire logic signed [tkes_pkg::FIT_W-1:0]  i_fitness,
    output tkes_pkg::t_dp_stat                      o_stat,
    output logic                                    o_valid,
    output logic [tkes_pkg::RANK_W-1:0]             o_rank,
    output logic [tkes_pkg::IDX_W-1:0]              o_chosen_index,
    output logic signed [tkes_pkg::FIT_W-1:0]       o_chosen_fitness,
    output logic                                    o_slot_filled,
    output logic                                    o_final_rank
);

    logic [tkes_pkg::IDX_W-1:0]        r_idx [tkes_pkg::ELITE_SLOTS];
    logic [tkes_pkg::IDX_W-1:0]        n_idx [tkes_pkg::ELITE_SLOTS];
    logic signed [tkes_pkg::FIT_W-1:0] r_fit [tkes_pkg::ELITE_SLOTS];
    logic signed [tkes_pkg::FIT_W-1:0] n_fit [tkes_pkg::ELITE_SLOTS];
    logic [tkes_pkg::ELITE_SLOTS-1:0]  r_valid;
    logic [tkes_pkg::ELITE_SLOTS-1:0]  n_valid;
    logic [tkes_pkg::CNT_W-1:0]        r_count;
    logic [tkes_pkg::CNT_W-1:0]        n_count;
    logic [tkes_pkg::ELITE_SLOTS-1:0]  w_gt;
    logic                              w_last;

    // slot keeps its entry when it beats the newcomer; the first slot that
    // does not takes the newcomer, the rest take the entry above
    for (genvar g = 0; g < tkes_pkg::ELITE_SLOTS; g++) begin : g_slot
        logic                              w_up_gt;
        logic [tkes_pkg::IDX_W-1:0]        w_up_idx;
        logic signed [tkes_pkg::FIT_W-1:0] w_up_fit;
        logic                              w_up_valid;
        logic [tkes_pkg::IDX_W-1:0]        w_dn_idx;
        logic signed [tkes_pkg::FIT_W-1:0] w_dn_fit;
        logic                              w_dn_valid;

        assign w_gt[g] = r_valid[g] && (r_fit[g] > i_fitness);

        if (g == 0) begin : g_top
            assign w_up_gt    = 1'b1;
            assign w_up_idx   = i_member_index;
            assign w_up_fit   = i_fitness;
            assign w_up_valid = 1'b1;
        end else begin : g_mid
            assign w_up_gt    = w_gt[g-1];
            assign w_up_idx   = r_idx[g-1];
            assign w_up_fit   = r_fit[g-1];
            assign w_up_valid = r_valid[g-1];
        end

        if (g == tkes_pkg::ELITE_SLOTS - 1) begin : g_bot
            assign w_dn_idx   = '0;
            assign w_dn_fit   = '0;
            assign w_dn_valid = 1'b0;
        end else begin : g_upper
            assign w_dn_idx   = r_idx[g+1];
            assign w_dn_fit   = r_fit[g+1];
            assign w_dn_valid = r_valid[g+1];
        end

        assign n_idx[g] = i_cmd.emit ? w_dn_idx :
                          (i_cmd.insert && !w_gt[g]) ?
                          (w_up_gt ? i_member_index : w_up_idx) : r_idx[g];
        assign n_fit[g] = i_cmd.emit ? w_dn_fit :
                          (i_cmd.insert && !w_gt[g]) ?
                          (w_up_gt ? i_fitness : w_up_fit) : r_fit[g];
        assign n_valid[g] = i_cmd.emit ? w_dn_valid :
                            (i_cmd.insert && !w_gt[g]) ?
                            (w_up_gt ? 1'b1 : w_up_valid) : r_valid[g];
    end

    assign w_last = (r_count == tkes_pkg::CNT_W'(tkes_pkg::ELITE_SLOTS - 1));

    always_comb begin
        n_count = r_count;
        if (i_cmd.emit) begin
            n_count = w_last ? '0 : r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_fit <= n_fit;
    end

    assign o_stat.last_slot = w_last;
    assign o_valid          = i_cmd.emit;
    assign o_rank           = tkes_pkg::RANK_W'(r_count);
    assign o_chosen_index   = r_valid[0] ? r_idx[0] : '0;
    assign o_chosen_fitness = r_valid[0] ? r_fit[0] : '0;
    assign o_slot_filled    = r_valid[0];
    assign o_final_rank     = w_last;

    a_cleared_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && w_last |=> r_valid == '0)
        else $error("slots not empty after readout");

    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_valid >> 1) & ~r_valid) == '0)
        else $error("empty slot above a filled one");

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.emit |-> r_count == '0)
        else $error("rank counter moved outside readout");

endmodule

`default_nettype wire

// ===== hdl/top_k_elite_selector.sv =====
// top level of the top-k elite selector
`default_nettype none

// usage
//  - a request is taken at a rising edge with start high and busy low; it
//    carries one individual: member index, signed fitness and population end
//  - each request is sorted into the eight-slot elite list in that same edge
//    by a parallel compare-and-shift over all slots, so while collecting one
//    request per cycle is taken
//  - a request with population end set is inserted first; busy then rises
//    while the list is read out best first, one result a cycle
//  - each result shows for one cycle with o_valid high: rank, index, fitness,
//    filled flag and final rank on the bottom slot; empty slots read as zero
//  - the readout shifts the list up one slot a cycle and feeds empty slots in
//    at the bottom, so the list is clear when busy falls
//  - the first result shows in the cycle after the final request is taken,
//    and the next request is taken in the cycle after the last result
//  - the receiver cannot stall; results are never held back
//  - reset empties the list and returns to collecting; no clearing pass
module top_k_elite_selector (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [tkes_pkg::IDX_W-1:0]         i_member_index,
    input  wire logic signed [tkes_pkg::FIT_W-1:0]  i_fitness,
    input  wire logic                               i_population_end,
    output logic                                    o_valid,
    output logic [tkes_pkg::RANK_W-1:0]             o_rank,
    output logic [tkes_pkg::IDX_W-1:0]              o_chosen_index,
    output logic signed [tkes_pkg::FIT_W-1:0]       o_chosen_fitness,
    output logic                                    o_slot_filled,
    output logic                                    o_final_rank
);

    // command and status between controller and datapath
    tkes_pkg::t_dp_cmd  w_cmd;
    tkes_pkg::t_dp_stat w_stat;

    // collect / readout sequencing
    tkes_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .i_population_end (i_population_end),
        .i_stat           (w_stat),
        .o_cmd            (w_cmd),
        .busy             (busy)
    );

    // elite slots and readout
    tkes_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_member_index   (i_member_index),
        .i_fitness        (i_fitness),
        .o_stat           (w_stat),
        .o_valid          (o_valid),
        .o_rank           (o_rank),
        .o_chosen_index   (o_chosen_index),
        .o_chosen_fitness (o_chosen_fitness),
        .o_slot_filled    (o_slot_filled),
        .o_final_rank     (o_final_rank)
    );

endmodule

`default_nettype wire
